FILE: design/stdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer deadline queue package
// Item layouts, action and status codes, and the control and status groups
// passed between the sequencer and the slot map.
// ----------------------------------------------------------------------------
package stdq_pkg;

  localparam int HANDLE_W = 6;
  localparam int SEC_W    = 32;
  localparam int USEC_W   = 20;
  localparam int HELD_W   = 7;
  localparam int KEY_W    = SEC_W + USEC_W;

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_REMOVE  = 2'd1;
  localparam logic [1:0] ACT_EXTRACT = 2'd2;
  localparam logic [1:0] ACT_PEEK    = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  typedef struct packed {
    logic [1:0]          action;
    logic [SEC_W-1:0]    key_seconds;
    logic [USEC_W-1:0]   key_microseconds;
    logic [HANDLE_W-1:0] handle;
  } stdq_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] result_handle;
    logic [SEC_W-1:0]    result_seconds;
    logic [USEC_W-1:0]   result_microseconds;
    logic [HELD_W-1:0]   entries_held;
  } stdq_rsp_t;

  // Seconds in the upper bits, so a plain unsigned compare orders deadlines.
  typedef struct packed {
    logic [SEC_W-1:0]  seconds;
    logic [USEC_W-1:0] microseconds;
  } stdq_key_t;

  typedef struct packed {
    logic scan_start;
    logic set_bit;
    logic clear_bit;
  } stdq_map_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic scan_found;
  } stdq_map_sts_t;

endpackage
`default_nettype wire

FILE: design/stdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/stdq_slot_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot occupancy map
// One in-use bit per slot and a scanner that finds the lowest free slot,
// testing one slot per cycle.
// ----------------------------------------------------------------------------
module stdq_slot_map #(
  parameter int QUEUE_DEPTH = 64,
  localparam int IW = $clog2(QUEUE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  stdq_pkg::stdq_map_cmd_t  cmd,
  input  logic [IW-1:0]            idx,
  output stdq_pkg::stdq_map_sts_t  sts,
  output logic [IW-1:0]            free_idx
);
  import stdq_pkg::*;

  logic [QUEUE_DEPTH-1:0] in_use;
  logic                   scanning;
  logic [IW-1:0]          sidx;
  logic [IW-1:0]          look;
  logic                   bit_val;

  always_comb begin
    look           = scanning ? sidx : idx;
    bit_val        = in_use[look];
    sts.hit        = bit_val;
    sts.scan_found = scanning && !bit_val;
    sts.scan_done  = scanning && (!bit_val || (sidx == IW'(QUEUE_DEPTH - 1)));
    free_idx       = sidx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use   <= '0;
      scanning <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scanning <= 1'b1;
        sidx     <= '0;
      end else if (sts.scan_done) begin
        scanning <= 1'b0;
      end else if (scanning) begin
        sidx <= sidx + IW'(1);
      end
      if (cmd.set_bit) begin
        in_use[idx] <= 1'b1;
      end
      if (cmd.clear_bit) begin
        in_use[idx] <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/stdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Queue sequencer
// Walks the sorted order list one position per cycle through a single key
// comparator, inserting or closing a gap as it goes.
// ----------------------------------------------------------------------------
module stdq_ctrl #(
  parameter int QUEUE_DEPTH = 64,
  localparam int IW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  stdq_pkg::stdq_req_t      req,
  output logic                     res_valid,
  input  logic                     res_ready,
  output stdq_pkg::stdq_rsp_t      res,
  output logic [IW-1:0]            ord_raddr,
  output logic                     ord_we,
  output logic [IW-1:0]            ord_waddr,
  output logic [IW-1:0]            ord_wdata,
  input  logic [IW-1:0]            ord_rdata,
  output logic [IW-1:0]            key_raddr,
  output logic                     key_we,
  output logic [IW-1:0]            key_waddr,
  output stdq_pkg::stdq_key_t      key_wdata,
  input  stdq_pkg::stdq_key_t      key_rdata,
  output stdq_pkg::stdq_map_cmd_t  map_cmd,
  output logic [IW-1:0]            map_idx,
  input  stdq_pkg::stdq_map_sts_t  map_sts,
  input  logic [IW-1:0]            free_idx
);
  import stdq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_KEY   = 3'd4;
  localparam logic [2:0] S_REM   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]          state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       rp;
  logic                v1;
  logic [CW-1:0]       pos1;
  logic                v2;
  logic [CW-1:0]       pos2;
  logic [IW-1:0]       slot2;
  logic                found;
  logic [IW-1:0]       carry;
  logic [IW-1:0]       new_slot;
  logic [IW-1:0]       tgt;
  logic [1:0]          action;
  stdq_key_t           new_key;
  logic [1:0]          r_status;
  logic [HANDLE_W-1:0] r_handle;
  stdq_key_t           r_key;

  logic ins_issue, ins_greater, ins_end, ins_place;
  logic rem_issue, rem_match, rem_last, rem_hit;
  logic hnd_ok;

  always_comb begin
    ins_issue   = (rp <= count);
    ins_greater = (new_key > key_rdata);
    ins_end     = v2 && (pos2 == count);
    // The new key goes ahead of the first stored key that is not smaller;
    // every later position is shifted up by one through the carry register.
    ins_place   = v2 && (found || !ins_greater || ins_end);
    rem_issue   = (rp < count);
    rem_match   = (ord_rdata == tgt);
    rem_last    = v1 && (pos1 == count - CW'(1));
    rem_hit     = found || rem_match;
    hnd_ok      = (32'(req.handle) < 32'(QUEUE_DEPTH)) && map_sts.hit;
  end

  always_comb begin
    ord_raddr = '0;
    ord_we    = 1'b0;
    ord_waddr = pos2[IW-1:0];
    ord_wdata = carry;
    key_raddr = ord_rdata;
    key_we    = 1'b0;
    key_waddr = new_slot;
    key_wdata = new_key;
    map_cmd   = '0;
    map_idx   = tgt;
    case (state)
      S_IDLE: begin
        map_idx            = IW'(req.handle);
        map_cmd.scan_start = req_valid && (req.action == ACT_INSERT) &&
                             (count != CW'(QUEUE_DEPTH));
      end
      S_SCAN: begin
        map_idx = new_slot;
      end
      S_INS: begin
        ord_raddr = rp[IW-1:0];
        map_idx   = new_slot;
        if (ins_place) begin
          ord_we = 1'b1;
        end
        if (ins_end) begin
          key_we          = 1'b1;
          map_cmd.set_bit = 1'b1;
        end
      end
      S_REM: begin
        ord_raddr = rp[IW-1:0];
        // Once the victim has been passed, each entry moves down one place.
        if (v1 && found) begin
          ord_we    = 1'b1;
          ord_waddr = IW'(pos1 - CW'(1));
          ord_wdata = ord_rdata;
        end
        if (rem_last && rem_hit) begin
          map_cmd.clear_bit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      found <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            action   <= req.action;
            new_key  <= {req.key_seconds, req.key_microseconds};
            tgt      <= IW'(req.handle);
            r_key    <= '0;
            rp       <= '0;
            v1       <= 1'b0;
            v2       <= 1'b0;
            found    <= 1'b0;
            case (req.action)
              ACT_INSERT: begin
                r_handle <= '0;
                if (count == CW'(QUEUE_DEPTH)) begin
                  r_status <= ST_FULL;
                  state    <= S_DONE;
                end else begin
                  r_status <= ST_OK;
                  state    <= S_SCAN;
                end
              end
              ACT_REMOVE: begin
                r_handle <= req.handle;
                if (hnd_ok && (count != '0)) begin
                  r_status <= ST_OK;
                  state    <= S_REM;
                end else begin
                  r_status <= ST_BAD_HANDLE;
                  state    <= S_DONE;
                end
              end
              ACT_EXTRACT, ACT_PEEK: begin
                r_handle <= '0;
                if (count == '0) begin
                  r_status <= ST_EMPTY;
                  state    <= S_DONE;
                end else begin
                  r_status <= ST_OK;
                  state    <= S_FETCH;
                end
              end
              default: begin
                r_handle <= '0;
                r_status <= ST_OK;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (map_sts.scan_done) begin
            if (map_sts.scan_found) begin
              new_slot <= free_idx;
              carry    <= free_idx;
              r_handle <= HANDLE_W'(free_idx);
              state    <= S_INS;
            end else begin
              r_status <= ST_FULL;
              state    <= S_DONE;
            end
          end
        end
        S_INS: begin
          v1    <= ins_issue;
          pos1  <= rp;
          if (ins_issue) begin
            rp <= rp + CW'(1);
          end
          v2    <= v1;
          pos2  <= pos1;
          slot2 <= ord_rdata;
          if (ins_place) begin
            carry <= slot2;
            found <= 1'b1;
          end
          if (ins_end) begin
            count <= count + CW'(1);
            state <= S_DONE;
          end
        end
        S_FETCH: begin
          tgt   <= ord_rdata;
          state <= S_KEY;
        end
        S_KEY: begin
          r_key    <= key_rdata;
          r_handle <= HANDLE_W'(tgt);
          if (action == ACT_EXTRACT) begin
            rp    <= '0;
            v1    <= 1'b0;
            found <= 1'b0;
            state <= S_REM;
          end else begin
            state <= S_DONE;
          end
        end
        S_REM: begin
          v1   <= rem_issue;
          pos1 <= rp;
          if (rem_issue) begin
            rp <= rp + CW'(1);
          end
          if (v1 && rem_match) begin
            found <= 1'b1;
          end
          if (rem_last) begin
            if (rem_hit) begin
              count <= count - CW'(1);
            end else begin
              r_status <= ST_BAD_HANDLE;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    req_ready               = (state == S_IDLE);
    res_valid               = (state == S_DONE);
    res.status              = r_status;
    res.result_handle       = r_handle;
    res.result_seconds      = r_key.seconds;
    res.result_microseconds = r_key.microseconds;
    res.entries_held        = HELD_W'(count);
  end

  // The order list is only rewritten by the two walks.
  a_ord_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    ord_we |-> (state == S_INS || state == S_REM))
    else $error("order list written outside a walk");

  // A new key may only land in a slot that is still free.
  a_key_write_free_slot: assert property (@(posedge clk) disable iff (rst)
    key_we |-> (state == S_INS && !map_sts.hit))
    else $error("key written into a slot already in use");

  // The entry count moves by at most one per cycle.
  a_count_step: assert property (@(posedge clk)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CW'(1) ||
                     count == $past(count) - CW'(1)))
    else $error("entry count jumped");

  // A free-slot scan is never started with the queue full.
  a_scan_has_room: assert property (@(posedge clk) disable iff (rst)
    map_cmd.scan_start |-> (count < CW'(QUEUE_DEPTH)))
    else $error("slot scan started on a full queue");

endmodule
`default_nettype wire

FILE: design/sorted_timer_deadline_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer deadline queue
// Keeps (seconds, microseconds) deadlines in ascending order in slot storage,
// with insert, remove by handle, extract earliest and peek earliest.
// ----------------------------------------------------------------------------
//   channel  handshake              payload     role
//   req      req_valid / req_ready  stdq_req_t  one action per item
//   rsp      rsp_valid / rsp_ready  stdq_rsp_t  one result item per request
//
// Insert runs a free-slot scan of one slot a cycle, then walks the order list
// one position a cycle through the key comparator; remove and extract also
// walk the order list, peek reads only its head; rejected actions skip both.
// The order walk is set by the single read port of the order RAM.
// Reset clears the in-use bits and the count; the RAMs are never cleared.
// A result waiting in the output register does not stop the next request.
module sorted_timer_deadline_queue_unit #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  stdq_pkg::stdq_req_t  req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output stdq_pkg::stdq_rsp_t  rsp
);
  import stdq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);

  logic          res_valid;
  logic          res_ready;
  stdq_rsp_t     res;
  logic [IW-1:0] ord_raddr, ord_waddr, ord_wdata, ord_rdata;
  logic          ord_we;
  logic [IW-1:0] key_raddr, key_waddr;
  logic          key_we;
  stdq_key_t     key_wdata, key_rdata;
  stdq_map_cmd_t map_cmd;
  stdq_map_sts_t map_sts;
  logic [IW-1:0] map_idx;
  logic [IW-1:0] free_idx;

  stdq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ord_raddr (ord_raddr),
    .ord_we    (ord_we),
    .ord_waddr (ord_waddr),
    .ord_wdata (ord_wdata),
    .ord_rdata (ord_rdata),
    .key_raddr (key_raddr),
    .key_we    (key_we),
    .key_waddr (key_waddr),
    .key_wdata (key_wdata),
    .key_rdata (key_rdata),
    .map_cmd   (map_cmd),
    .map_idx   (map_idx),
    .map_sts   (map_sts),
    .free_idx  (free_idx)
  );

  stdq_slot_map #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_slot_map (
    .clk      (clk),
    .rst      (rst),
    .cmd      (map_cmd),
    .idx      (map_idx),
    .sts      (map_sts),
    .free_idx (free_idx)
  );

  stdq_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  stdq_ram #(.WIDTH(KEY_W), .DEPTH(QUEUE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // Output register: the sequencer hands over its result whenever the
  // register is empty or being drained in the same cycle.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer deadline queue testbench
// A queued driver feeds actions into the deadline queue with random gaps. A
// monitor takes results with random stalls and checks each field against a
// local model of the sorted slot list. Two long receiver hold-offs fill the
// pipeline, and two full fill and drain runs reach the full and empty cases.
// ----------------------------------------------------------------------------
module testbench;
  import stdq_pkg::*;

  localparam int QDEPTH        = 64;
  localparam int RANDOM_ITEMS  = 800;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    stdq_req_t req;
    int        gap;
    bit        drain_first;
  } pending_item_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  stdq_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  stdq_rsp_t rsp;

  sorted_timer_deadline_queue_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  // Local copy of the queue contents, advanced once per accepted item.
  logic [SEC_W-1:0]    held_seconds      [QDEPTH];
  logic [USEC_W-1:0]   held_microseconds [QDEPTH];
  bit                  slot_taken        [QDEPTH];
  logic [HANDLE_W-1:0] deadline_order[$];

  pending_item_t pending_items[$];
  stdq_rsp_t     awaited_results[$];
  int            items_queued   = 0;
  int            items_accepted = 0;
  int            results_seen   = 0;
  int            fault_count    = 0;
  int            cycle_count    = 0;
  int            hold_left      = 0;
  int            holds_done     = 0;

  pending_item_t staged_item;
  bit            staged = 1'b0;
  int            tx_wait = 0;
  int            rx_stall = 0;

  function automatic stdq_rsp_t apply_timer_action(input stdq_req_t r);
    stdq_rsp_t o;
    stdq_key_t new_key;
    stdq_key_t there;
    int        slot;
    int        pos;
    o = '0;
    o.status = ST_OK;
    case (r.action)
      ACT_INSERT: begin
        if (deadline_order.size() >= QDEPTH) begin
          o.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < QDEPTH && slot_taken[slot]) slot++;
          new_key.seconds = r.key_seconds;
          new_key.microseconds = r.key_microseconds;
          pos = 0;
          // Walk past strictly smaller keys only, so a new key lands ahead of equals.
          while (pos < deadline_order.size()) begin
            there = {held_seconds[deadline_order[pos]], held_microseconds[deadline_order[pos]]};
            if (!(new_key > there)) break;
            pos++;
          end
          deadline_order.insert(pos, slot[HANDLE_W-1:0]);
          held_seconds[slot] = r.key_seconds;
          held_microseconds[slot] = r.key_microseconds;
          slot_taken[slot] = 1'b1;
          o.result_handle = slot[HANDLE_W-1:0];
        end
      end
      ACT_REMOVE: begin
        o.result_handle = r.handle;
        if (!slot_taken[r.handle]) begin
          o.status = ST_BAD_HANDLE;
        end else begin
          for (int i = 0; i < deadline_order.size(); i++) begin
            if (deadline_order[i] == r.handle) begin
              deadline_order.delete(i);
              break;
            end
          end
          slot_taken[r.handle] = 1'b0;
        end
      end
      default: begin
        if (deadline_order.size() == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.result_handle = deadline_order[0];
          o.result_seconds = held_seconds[deadline_order[0]];
          o.result_microseconds = held_microseconds[deadline_order[0]];
          if (r.action == ACT_EXTRACT) begin
            slot_taken[deadline_order[0]] = 1'b0;
            deadline_order.delete(0);
          end
        end
      end
    endcase
    o.entries_held = HELD_W'(deadline_order.size());
    return o;
  endfunction

  function automatic stdq_req_t make_action(input logic [1:0] act, input int unsigned sec,
                                            input int unsigned usec,
                                            input int unsigned hnd);
    stdq_req_t r;
    r.action = act;
    r.key_seconds = SEC_W'(sec);
    r.key_microseconds = USEC_W'(usec);
    r.handle = HANDLE_W'(hnd);
    return r;
  endfunction

  // Narrow key ranges are favoured so that ties and near ties are common.
  function automatic stdq_req_t random_insert();
    int unsigned sec;
    int unsigned usec;
    case ($urandom_range(0, 3))
      0: begin
        sec = $urandom_range(0, 3);
        usec = $urandom_range(0, 3);
      end
      1: begin
        sec = $urandom;
        usec = $urandom_range(0, 999999);
      end
      2: begin
        sec = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        usec = $urandom;
      end
      default: begin
        sec = $urandom_range(100, 103);
        usec = $urandom_range(999990, 1048575);
      end
    endcase
    return make_action(ACT_INSERT, sec, usec, $urandom);
  endfunction

  // Mostly a handle that is live in the model, otherwise any handle at all.
  function automatic int unsigned pick_handle();
    int unsigned live[$];
    for (int s = 0; s < QDEPTH; s++) begin
      if (slot_taken[s]) live.push_back(s);
    end
    if (live.size() == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, QDEPTH - 1);
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  task automatic queue_item(input stdq_req_t r, input bit calm, input bit drain);
    pending_item_t p;
    p.req = r;
    p.gap = calm ? 0 : $urandom_range(0, 14);
    p.drain_first = drain;
    pending_items.push_back(p);
    items_queued++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fault_count++;
    end
  endtask

  // Driver: holds an item until accepted, then waits out the next item's gap.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      staged = 1'b0;
      tx_wait = 0;
    end else begin
      if (req_valid && req_ready) begin
        awaited_results.push_back(apply_timer_action(req));
        items_accepted++;
      end
      if (!(req_valid && !req_ready)) begin
        if (!staged && pending_items.size() != 0) begin
          staged_item = pending_items.pop_front();
          staged = 1'b1;
          tx_wait = staged_item.gap;
        end
        if (staged && tx_wait == 0 &&
            !(staged_item.drain_first && awaited_results.size() != 0)) begin
          req_valid <= 1'b1;
          req <= staged_item.req;
          staged = 1'b0;
        end else begin
          req_valid <= 1'b0;
          if (staged && tx_wait > 0) tx_wait--;
        end
      end
    end
  end

  // Long receiver hold-offs, so that the block backs up and refuses new items.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && items_accepted >= 150) ||
                 (holds_done == 1 && items_accepted >= 520)) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: checks each result against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result item arrived with nothing expected");
          fault_count++;
        end else begin
          stdq_rsp_t want;
          want = awaited_results.pop_front();
          compare_field("status", 64'(want.status), 64'(rsp.status));
          compare_field("result_handle", 64'(want.result_handle), 64'(rsp.result_handle));
          compare_field("result_seconds", 64'(want.result_seconds), 64'(rsp.result_seconds));
          compare_field("result_microseconds", 64'(want.result_microseconds),
                        64'(rsp.result_microseconds));
          compare_field("entries_held", 64'(want.entries_held), 64'(rsp.entries_held));
        end
        results_seen++;
        // Every third stretch of fifty results is taken without stalls.
        rx_stall = ((results_seen / 50) % 3 == 0) ? 0 : $urandom_range(0, 14);
      end
      if (rx_stall > 0 || hold_left != 0) begin
        rsp_ready <= 1'b0;
        if (rx_stall > 0) rx_stall--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    bit calm;
    int pick;
    int fills;
    fills = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty queue, unused handles, ties, key extremes, reuse.
    queue_item(make_action(ACT_PEEK, 0, 0, 0), 0, 0);
    queue_item(make_action(ACT_EXTRACT, 0, 0, 0), 0, 0);
    queue_item(make_action(ACT_REMOVE, 0, 0, 0), 0, 0);
    queue_item(make_action(ACT_REMOVE, 0, 0, 63), 0, 0);
    queue_item(make_action(ACT_INSERT, 5, 7, 0), 0, 0);
    queue_item(make_action(ACT_INSERT, 5, 7, 63), 0, 0);
    queue_item(make_action(ACT_INSERT, 32'hFFFF_FFFF, 32'h000F_FFFF, 0), 0, 0);
    queue_item(make_action(ACT_INSERT, 0, 0, 0), 0, 0);
    queue_item(make_action(ACT_INSERT, 5, 6, 0), 0, 0);
    queue_item(make_action(ACT_INSERT, 0, 999999, 0), 0, 0);
    queue_item(make_action(ACT_INSERT, 5, 1000000, 0), 0, 0);
    queue_item(make_action(ACT_PEEK, 0, 0, 0), 0, 0);
    queue_item(make_action(ACT_EXTRACT, 0, 0, 0), 0, 0);
    queue_item(make_action(ACT_REMOVE, 0, 0, 1), 0, 0);
    queue_item(make_action(ACT_REMOVE, 0, 0, 1), 0, 0);
    queue_item(make_action(ACT_INSERT, 1, 1, 0), 0, 0);
    queue_item(make_action(ACT_REMOVE, 0, 0, 42), 0, 0);
    repeat (7) queue_item(make_action(ACT_EXTRACT, 0, 0, 0), 0, 0);
    queue_item(make_action(ACT_PEEK, 0, 0, 0), 0, 0);

    while (items_queued < 25 + RANDOM_ITEMS) begin
      while (pending_items.size() > 2) @(negedge clk);
      calm = ($urandom_range(0, 3) == 0);
      if ((fills == 0 && items_queued >= 300) || (fills == 1 && items_queued >= 600)) begin
        // Fill past capacity, then extract past empty.
        queue_item(random_insert(), calm, 1);
        repeat (65) queue_item(random_insert(), calm, 0);
        for (int i = 0; i < 80; i++) begin
          queue_item(make_action((i % 9 == 4) ? ACT_PEEK : ACT_EXTRACT, $urandom, $urandom,
                                 $urandom), calm, 0);
        end
        fills++;
      end else begin
        for (int i = 0; i < 8; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 10) begin
            queue_item(make_action(2'($urandom), $urandom, $urandom, $urandom), calm,
                       ($urandom_range(0, 29) == 0));
          end else if (pick < 50) begin
            queue_item(random_insert(), calm, 0);
          end else if (pick < 68) begin
            queue_item(make_action(ACT_REMOVE, $urandom, $urandom, pick_handle()), calm, 0);
          end else if (pick < 85) begin
            queue_item(make_action(ACT_EXTRACT, $urandom, $urandom, $urandom), calm, 0);
          end else begin
            queue_item(make_action(ACT_PEEK, $urandom, $urandom, $urandom), calm, 0);
          end
        end
      end
    end

    while (items_accepted != items_queued || awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
